// File: rtl/cfbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cepstral frequency band mask: shared package
// Widths, DCT and inverse DCT tables, and the command and control structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cfbm_pkg;

	localparam int NUM_COEFFS = 40;
	localparam int MAX_FRAMES = 256;
	localparam int MAX_BAND   = 13;
	localparam int LIFTER     = 22;

	localparam int CW     = 16;   // coefficient width, Q7.8
	localparam int TW     = 20;   // table entry width, Q15 with lifter gain
	localparam int FBW    = 25;   // filterbank value width, Q8
	localparam int MW     = 24;   // band mean width
	localparam int SW     = 32;   // band sum width
	localparam int PW     = FBW + TW;
	localparam int ACCW   = 52;   // accumulator width
	localparam int CNTW   = 9;    // frame counter width
	localparam int POSW   = $clog2(NUM_COEFFS);
	localparam int BANDW  = $clog2(MAX_BAND);
	localparam int TAB_N  = NUM_COEFFS * NUM_COEFFS;
	localparam int TADDRW = $clog2(TAB_N);

	typedef logic signed [TW-1:0] tab_t;
	typedef tab_t tab_arr_t [TAB_N];

	// One multiply-accumulate step issued by the controller.
	typedef struct packed {
		logic            valid;
		logic            dct;     // 1: forward DCT, 0: inverse DCT
		logic            first;   // first term of a row
		logic            last;    // last term of a row
		logic            zero;    // coefficient beyond a short frame
		logic [POSW-1:0] row;
		logic [POSW-1:0] col;
	} cmd_t;

	// Frame-level control from the controller to the datapath.
	typedef struct packed {
		logic             fs_we;
		logic [POSW-1:0]  fs_addr;
		logic             subst;      // rewrite pass: replace band by mean
		logic             accum;      // statistics pass: add band to sums
		logic             uend;
		logic             div_start;
		logic [BANDW-1:0] div_idx;
		logic [CNTW-1:0]  frames;
	} dp_ctl_t;

	// Table generation, evaluated at elaboration.
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint          ONE_Q30 = 64'sd1 <<< 30;
	localparam longint          HALF15  = 64'sd1 <<< 14;
	localparam longint          HALF30  = 64'sd1 <<< 29;
	localparam longint unsigned TAYLOR_DIV [1:8] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182, 64'd240};
	localparam longint LIFT_B = 2 * LIFTER;
	localparam longint LIFT_M = 2 * LIFT_B;
	localparam longint DCT_B  = 2 * NUM_COEFFS;
	localparam longint DCT_M  = 2 * DCT_B;
	localparam longint unsigned N0_SQ = (64'd1 << 60) / NUM_COEFFS;
	localparam longint unsigned N1_SQ = (64'd1 << 61) / NUM_COEFFS;

	// Unsigned long division by shift and subtract.
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Brings a into the range [0, m).
	function automatic longint wrap_mod(longint a, longint m);
		longint r;
		r = a;
		while (r < 0) r = r + m;
		while (r >= m) r = r - m;
		return r;
	endfunction

	function automatic longint cos_series(longint unsigned x, logic neg);
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x2 = (x * x) >> 30;
		term = longint'(ONE_Q30);
		sum = ONE_Q30;
		for (int i = 1; i <= 8; i++) begin
			term = udiv64((term * x2) >> 30, TAYLOR_DIV[i]);
			if (i[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return neg ? -sum : sum;
	endfunction

	// cos(pi * a / LIFT_B) in Q30
	function automatic longint cos_lift(longint a);
		longint r;
		logic neg;
		longint unsigned x;
		neg = 1'b0;
		r = wrap_mod(a, LIFT_M);
		if (r > LIFT_B) r = LIFT_M - r;
		if (2 * r > LIFT_B) begin
			r = LIFT_B - r;
			neg = 1'b1;
		end
		x = udiv64(PI_Q30 * longint'(r), LIFT_B);
		return cos_series(x, neg);
	endfunction

	// cos(pi * a / DCT_B) in Q30
	function automatic longint cos_dct(longint a);
		longint r;
		logic neg;
		longint unsigned x;
		neg = 1'b0;
		r = wrap_mod(a, DCT_M);
		if (r > DCT_B) r = DCT_M - r;
		if (2 * r > DCT_B) begin
			r = DCT_B - r;
			neg = 1'b1;
		end
		x = udiv64(PI_Q30 * longint'(r), DCT_B);
		return cos_series(x, neg);
	endfunction

	function automatic longint unsigned isqrt64(longint unsigned v);
		longint unsigned res;
		longint unsigned bt;
		longint unsigned rem;
		res = 0;
		rem = v;
		bt = 64'd1 << 62;
		while (bt > rem) bt = bt >> 2;
		while (bt != 0) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic longint div_round(longint a, longint b);
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned q;
		ua = (a < 0) ? longint'(-a) : longint'(a);
		ub = (b < 0) ? longint'(-b) : longint'(b);
		q = udiv64(ua + (ub >> 1), ub);
		return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// inverse = 1 gives the inverse table at [n*N+k], else the forward at [k*N+n].
	function automatic tab_arr_t build_tab(logic inverse);
		tab_arr_t t;
		longint n0;
		longint n1;
		longint s;
		longint lift;
		longint base;
		longint v;
		int idx;
		n0 = longint'(isqrt64(N0_SQ));
		n1 = longint'(isqrt64(N1_SQ));
		for (int k = 0; k < NUM_COEFFS; k++) begin
			s = cos_lift(longint'(LIFTER) - 2 * k);
			lift = (ONE_Q30 + ((longint'(LIFTER) * s) >>> 1) + HALF15) >>> 15;
			for (int n = 0; n < NUM_COEFFS; n++) begin
				if (k == 0) begin
					v = (n0 + HALF15) >>> 15;
				end else begin
					base = (n1 * cos_dct(longint'(2 * n + 1) * k) + HALF30) >>> 30;
					if (inverse)
						v = (lift == 0) ? 64'sd0 : div_round(base, lift);
					else
						v = (base * lift + HALF30) >>> 30;
				end
				idx = inverse ? (n * NUM_COEFFS + k) : (k * NUM_COEFFS + n);
				t[idx] = tab_t'(v[TW-1:0]);
			end
		end
		return t;
	endfunction

	localparam tab_arr_t DCT_TAB  = build_tab(1'b0);
	localparam tab_arr_t IDCT_TAB = build_tab(1'b1);

endpackage
`default_nettype wire

// File: rtl/cfbm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Band mean divider
// Restoring divider, one quotient bit per cycle, for band sum by frame count.
// ----------------------------------------------------------------------------
module cfbm_div
	import cfbm_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [SW:0]     dividend,
	input  wire logic [CNTW-1:0] divisor,
	output logic                 done,
	output logic [SW:0]          quotient
);

	localparam int STEPS = SW + 1;
	localparam int STW   = $clog2(STEPS + 1);

	logic [SW:0]      dvd_q;
	logic [CNTW:0]    rem_q;
	logic [STW-1:0]   cnt_q;
	logic             done_q;
	logic [CNTW:0]    rem_sh;
	logic             fits;

	// Shift in the next dividend bit and try a subtraction.
	assign rem_sh = {rem_q[CNTW-1:0], dvd_q[SW]};
	assign fits   = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STW'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STW'(1))
					done_q <= 1'b1;
			end
		end
	end

	// The quotient bits shift into the dividend register as it empties.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
			dvd_q <= {dvd_q[SW-1:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

// File: rtl/cfbm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cepstral frequency band mask: datapath
// Frame store, filterbank store, table ROMs, the shared multiply-accumulate
// pipeline, band statistics and output register.
// ----------------------------------------------------------------------------
module cfbm_datapath
	import cfbm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire dp_ctl_t               ctl,
	input  wire logic signed [CW-1:0]  coeff_in,
	input  wire logic [5:0]            band_start,
	input  wire logic [3:0]            band_width,
	output logic                       div_done,
	output logic                       out_valid,
	output logic signed [CW-1:0]       coeff_out,
	output logic                       frame_end,
	output logic                       utterance_last,
	output logic                       clipped
);

	localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(1) <<< 14;
	localparam logic signed [ACCW-1:0] OUT_MAX  = ACCW'(32767);
	localparam logic signed [ACCW-1:0] OUT_MIN  = -ACCW'(32768);
	localparam logic [SW:0]            MEAN_MAX = (SW+1)'(8388607);
	localparam logic [SW:0]            MEAN_NEG = (SW+1)'(8388608);

	logic signed [CW-1:0]  frame_store [NUM_COEFFS];
	logic signed [FBW-1:0] fb_mem      [NUM_COEFFS];
	logic signed [SW-1:0]  band_sum    [MAX_BAND];
	logic signed [MW-1:0]  band_mean   [MAX_BAND];

	logic [TADDRW-1:0]     taddr;
	logic                  v_s1, dct_s1, first_s1, last_s1, zero_s1;
	logic [POSW-1:0]       row_s1;
	logic signed [FBW-1:0] opa_s1;
	tab_t                  tab_s1;
	logic                  v_s2, dct_s2, first_s2, last_s2;
	logic [POSW-1:0]       row_s2;
	logic signed [PW-1:0]  prod_s2;
	logic signed [FBW-1:0] opa_eff;
	logic signed [PW-1:0]  prod_c;
	logic signed [ACCW-1:0] acc_q;
	logic                  fin_s3, dct_s3;
	logic [POSW-1:0]       row_s3;

	logic signed [ACCW-1:0] rnd_c;
	logic signed [FBW-1:0]  fb_c;
	logic [3:0]             w_c;
	logic [POSW:0]          diff_c;
	logic                   inband;
	logic [BANDW-1:0]       bidx;
	logic signed [SW:0]     sum_ext;
	logic signed [SW:0]     sum_new;
	logic signed [SW-1:0]   sum_sat;

	logic signed [SW-1:0]   dsum;
	logic [SW:0]            dabs;
	logic [SW:0]            dvd_c;
	logic [SW:0]            quo;
	logic signed [MW-1:0]   mean_c;

	logic                   out_valid_q;
	logic signed [CW-1:0]   coeff_q;
	logic                   frame_end_q, utt_last_q, clip_q;

	// Table address: row-major over the forward or inverse matrix.
	assign taddr = TADDRW'(cmd.row) * TADDRW'(NUM_COEFFS) + TADDRW'(cmd.col);

	// Frame store write and stage 1 reads of stores and tables.
	always_ff @(posedge clk) begin
		if (ctl.fs_we)
			frame_store[ctl.fs_addr] <= coeff_in;
		opa_s1   <= cmd.dct ? fb_mem[cmd.col] : FBW'(frame_store[cmd.col]);
		tab_s1   <= cmd.dct ? DCT_TAB[taddr] : IDCT_TAB[taddr];
		dct_s1   <= cmd.dct;
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		zero_s1  <= cmd.zero;
		row_s1   <= cmd.row;
	end

	// Stage 2: the multiply; missing coefficients of a short frame count as zero.
	assign opa_eff = zero_s1 ? '0 : opa_s1;
	assign prod_c  = opa_eff * tab_s1;

	always_ff @(posedge clk) begin
		prod_s2  <= prod_c;
		dct_s2   <= dct_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
	end

	// Stage 3: accumulate one row.
	always_ff @(posedge clk) begin
		if (v_s2)
			acc_q <= (first_s2 ? '0 : acc_q) + ACCW'(prod_s2);
		dct_s3 <= dct_s2;
		row_s3 <= row_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			fin_s3 <= 1'b0;
		end else begin
			v_s1   <= cmd.valid;
			v_s2   <= v_s1;
			fin_s3 <= v_s2 && last_s2;
		end
	end

	// Rounding and band membership of the finished row.
	assign rnd_c   = (acc_q + RND_HALF) >>> 15;
	assign fb_c    = rnd_c[FBW-1:0];
	assign w_c     = (band_width > 4'(MAX_BAND)) ? 4'(MAX_BAND) : band_width;
	assign diff_c  = {1'b0, row_s3} - {1'b0, band_start};
	assign inband  = !diff_c[POSW] && (diff_c[POSW-1:0] < POSW'(w_c));
	assign bidx    = diff_c[BANDW-1:0];
	assign sum_ext = (SW+1)'(band_sum[bidx]);
	assign sum_new = sum_ext + (SW+1)'(fb_c);
	assign sum_sat = (sum_new[SW] != sum_new[SW-1])
		? {sum_new[SW], {(SW-1){!sum_new[SW]}}} : sum_new[SW-1:0];

	// Filterbank store: band channels take the mean in the rewrite pass.
	always_ff @(posedge clk) begin
		if (fin_s3 && !dct_s3)
			fb_mem[row_s3] <= (ctl.subst && inband) ? FBW'(band_mean[bidx]) : fb_c;
	end

	// Mean division: magnitude plus half the count, sign restored at the end.
	assign dsum  = band_sum[ctl.div_idx];
	assign dabs  = dsum[SW-1] ? -(SW+1)'(dsum) : (SW+1)'(dsum);
	assign dvd_c = dabs + (SW+1)'(ctl.frames >> 1);

	cfbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (dvd_c),
		.divisor  (ctl.frames),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		if (ctl.frames == '0)
			mean_c = '0;
		else if (dsum[SW-1])
			mean_c = (quo > MEAN_NEG) ? {1'b1, {(MW-1){1'b0}}} : -quo[MW-1:0];
		else
			mean_c = (quo > MEAN_MAX) ? {1'b0, {(MW-1){1'b1}}} : quo[MW-1:0];
	end

	// Band sums and means: accumulate per frame, fold into means at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BAND; i++) begin
				band_sum[i]  <= '0;
				band_mean[i] <= '0;
			end
		end else begin
			if (div_done) begin
				band_mean[ctl.div_idx] <= mean_c;
				band_sum[ctl.div_idx]  <= '0;
			end else if (fin_s3 && !dct_s3 && ctl.accum && inband) begin
				band_sum[bidx] <= sum_sat;
			end
		end
	end

	// Output register for the rewrite pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else
			out_valid_q <= fin_s3 && dct_s3;
	end

	always_ff @(posedge clk) begin
		if (fin_s3 && dct_s3) begin
			clip_q <= (rnd_c > OUT_MAX) || (rnd_c < OUT_MIN);
			if (rnd_c > OUT_MAX)
				coeff_q <= 16'sh7FFF;
			else if (rnd_c < OUT_MIN)
				coeff_q <= 16'sh8000;
			else
				coeff_q <= rnd_c[CW-1:0];
			frame_end_q <= row_s3 == POSW'(NUM_COEFFS - 1);
			utt_last_q  <= (row_s3 == POSW'(NUM_COEFFS - 1)) && ctl.uend;
		end
	end

	assign out_valid      = out_valid_q;
	assign coeff_out      = coeff_q;
	assign frame_end      = frame_end_q;
	assign utterance_last = utt_last_q;
	assign clipped        = clip_q;

endmodule
`default_nettype wire

// File: rtl/cfbm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cepstral frequency band mask: controller
// Collects a frame, then sequences the inverse DCT, followed by the forward
// DCT or the end-of-utterance mean division.
// ----------------------------------------------------------------------------
module cfbm_ctrl
	import cfbm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic pass_select,
	input  wire logic utterance_end,
	input  wire logic div_done,
	output logic      busy,
	output cmd_t      cmd,
	output dp_ctl_t   ctl
);

	localparam int DRAIN = 4;   // pipeline depth from issue to write-back

	typedef enum logic [2:0] {
		S_IDLE, S_IDCT, S_IDRAIN, S_DCT, S_DDRAIN, S_DIV_GO, S_DIV_WAIT
	} state_t;

	state_t           state_q;
	logic [POSW-1:0]  pos_q, len_q, row_q, col_q;
	logic             pass_q, uend_q;
	logic [2:0]       drain_q;
	logic [CNTW-1:0]  cnt_q;
	logic [BANDW-1:0] bidx_q;
	logic             accept;
	logic             row_end, mat_end;

	assign accept  = start && (state_q == S_IDLE);
	assign row_end = col_q == POSW'(NUM_COEFFS - 1);
	assign mat_end = row_end && (row_q == POSW'(NUM_COEFFS - 1));

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			pass_q  <= 1'b0;
			uend_q  <= 1'b0;
			drain_q <= '0;
			cnt_q   <= '0;
			bidx_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (pos_q == POSW'(NUM_COEFFS - 1) || utterance_end) begin
							len_q   <= pos_q + 1'b1;
							pass_q  <= pass_select;
							uend_q  <= utterance_end;
							pos_q   <= '0;
							row_q   <= '0;
							col_q   <= '0;
							state_q <= S_IDCT;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_IDCT, S_DCT: begin
					if (row_end) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					if (mat_end) begin
						drain_q <= '0;
						state_q <= (state_q == S_IDCT) ? S_IDRAIN : S_DDRAIN;
					end
				end
				S_IDRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 3'(DRAIN - 1)) begin
						if (pass_q) begin
							row_q   <= '0;
							col_q   <= '0;
							state_q <= S_DCT;
						end else begin
							if (cnt_q < CNTW'(MAX_FRAMES))
								cnt_q <= cnt_q + 1'b1;
							bidx_q  <= '0;
							state_q <= uend_q ? S_DIV_GO : S_IDLE;
						end
					end
				end
				S_DDRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 3'(DRAIN - 1))
						state_q <= S_IDLE;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						if (bidx_q == BANDW'(MAX_BAND - 1)) begin
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							bidx_q  <= bidx_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.valid = (state_q == S_IDCT) || (state_q == S_DCT);
		cmd.dct   = state_q == S_DCT;
		cmd.first = col_q == '0;
		cmd.last  = row_end;
		cmd.zero  = (state_q == S_IDCT) && (col_q >= len_q);
		cmd.row   = row_q;
		cmd.col   = col_q;

		ctl.fs_we     = accept;
		ctl.fs_addr   = pos_q;
		ctl.subst     = pass_q;
		ctl.accum     = !pass_q && (cnt_q < CNTW'(MAX_FRAMES));
		ctl.uend      = uend_q;
		ctl.div_start = state_q == S_DIV_GO;
		ctl.div_idx   = bidx_q;
		ctl.frames    = cnt_q;
	end

	assign busy = state_q != S_IDLE;

endmodule
`default_nettype wire

// File: rtl/cepstral_frequency_band_mask_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cepstral frequency band mask: top level
// Configuration registers and the controller and datapath.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low. An item that
// does not complete a frame leaves busy low. The item that completes a frame
// raises busy while one shared multiply-accumulate unit runs the 40 x 40
// inverse DCT and drains its pipeline; a rewrite-pass frame then runs the
// 40 x 40 forward DCT, emitting its 40 items on out_valid, one per finished
// row, the last in the final cycle of busy. The receiver cannot stall: every
// result is present for exactly one cycle. The last statistics-pass frame
// adds 13 mean divisions, one per band.
module cepstral_frequency_band_mask_top
	import cfbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 pass_select,
	input  wire logic signed [CW-1:0] coeff_in,
	input  wire logic                 utterance_end,
	output logic                      out_valid,
	output logic signed [CW-1:0]      coeff_out,
	output logic                      frame_end,
	output logic                      utterance_last,
	output logic                      clipped,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	typedef enum logic {
		REG_BAND_START = 1'b0,
		REG_BAND_WIDTH = 1'b1
	} reg_idx_t;

	logic [5:0] band_start_q;
	logic [3:0] band_width_q;
	cmd_t       cmd;
	dp_ctl_t    ctl;
	logic       div_done;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_start_q <= '0;
			band_width_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[2]))
				REG_BAND_START: band_start_q <= pwdata[5:0];
				REG_BAND_WIDTH: band_width_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_BAND_START: prdata = {26'b0, band_start_q};
			REG_BAND_WIDTH: prdata = {28'b0, band_width_q};
			default:        prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	cfbm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.pass_select   (pass_select),
		.utterance_end (utterance_end),
		.div_done      (div_done),
		.busy          (busy),
		.cmd           (cmd),
		.ctl           (ctl)
	);

	cfbm_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.ctl            (ctl),
		.coeff_in       (coeff_in),
		.band_start     (band_start_q),
		.band_width     (band_width_q),
		.div_done       (div_done),
		.out_valid      (out_valid),
		.coeff_out      (coeff_out),
		.frame_end      (frame_end),
		.utterance_last (utterance_last),
		.clipped        (clipped)
	);

endmodule
`default_nettype wire
